// File: rtl/core/apt_pkg.sv
// Shared types and constants of the adaptive pedestal tracker.
`default_nettype none

package apt_pkg;

    // Field widths of the command and report beats.
    localparam int CMD_W      = 2;
    localparam int CH_W       = 4;
    localparam int VAL_W      = 17;
    localparam int PED_W      = 20;
    localparam int THR_W      = 21;
    localparam int OCNT_W     = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int MINP_W     = 16;
    localparam int NCH_W      = 5;
    localparam int TRIG_W     = 14;

    // Stored state widths.
    localparam int SUM_W      = 40;
    localparam int LIMIT_W    = 17;
    localparam int FRAC_W     = 4;
    localparam int DIVD_W     = SUM_W + FRAC_W;

    // Arithmetic constants.
    localparam logic [LIMIT_W-1:0] LIMIT_MAX  = 17'h1FFFF;
    localparam logic [LIMIT_W:0]   LIMIT_OFS  = 18'd100;
    localparam logic [THR_W-1:0]   THR_OFS    = 21'd240;
    localparam logic [PED_W-1:0]   PED_MAX    = 20'hFFFFF;
    localparam logic [OCNT_W-1:0]  OCNT_MAX   = 24'hFFFFFF;
    localparam logic [16:0]        DIV5_RECIP = 17'd52429;
    localparam int                 DIV5_SHIFT = 18;

    // Reset values of the configuration registers.
    localparam logic [MINP_W-1:0] MINP_RST  = 16'd500;
    localparam logic [TRIG_W-1:0] TRIG_RST  = TRIG_W'(500 / 5);
    localparam logic [NCH_W-1:0]  NCH_RST   = 5'd16;
    localparam int                MAX_RPT   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_REPORT = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PEDS = 1'b0,
        CFG_NUM_CHAN = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_LIM,
        S_WRD,
        S_WDIV,
        S_WWAIT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [DIVD_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic [CH_W-1:0]   out_channel;
        logic [PED_W-1:0]  pedestal_q4;
        logic [THR_W-1:0]  threshold_q4;
        logic [PED_W-1:0]  held_mean_q4;
        logic [OCNT_W-1:0] sample_count;
        logic              mean_updated;
        logic              last;
    } t_rpt;

endpackage

`default_nettype wire

// File: rtl/core/apt_in_if.sv
// Command channel of the adaptive pedestal tracker.
`default_nettype none

interface apt_in_if;
    logic                 valid;
    logic                 ready;
    logic [apt_pkg::CMD_W-1:0] command;
    logic [apt_pkg::CH_W-1:0]  channel;
    logic [apt_pkg::VAL_W-1:0] value;

    modport source (output valid, output command, output channel, output value,
                    input ready);
    modport sink   (input valid, input command, input channel, input value,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/apt_out_if.sv
// Report channel of the adaptive pedestal tracker.
`default_nettype none

interface apt_out_if;
    logic                       valid;
    logic                       ready;
    logic [apt_pkg::CH_W-1:0]   out_channel;
    logic [apt_pkg::PED_W-1:0]  pedestal_q4;
    logic [apt_pkg::THR_W-1:0]  threshold_q4;
    logic [apt_pkg::PED_W-1:0]  held_mean_q4;
    logic [apt_pkg::OCNT_W-1:0] sample_count;
    logic                       mean_updated;
    logic                       last;

    modport source (output valid, output out_channel, output pedestal_q4,
                    output threshold_q4, output held_mean_q4, output sample_count,
                    output mean_updated, output last, input ready);
    modport sink   (input valid, input out_channel, input pedestal_q4,
                    input threshold_q4, input held_mean_q4, input sample_count,
                    input mean_updated, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/apt_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module apt_div #(
    parameter int CNT_W = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire apt_pkg::t_div_req       i_req,
    input  wire logic [CNT_W-1:0]        i_divisor,
    output apt_pkg::t_div_rsp            o_rsp
);
    import apt_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W);

    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    logic [CNT_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_dvs;
    logic [DIVD_W-1:0]   r_quo;

    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;
    logic                ge;

    // The dividend shifts out of the top of r_quo while quotient bits enter below.
    always_comb begin
        trial = {r_rem, r_quo[DIVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(DIVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], ge};
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_quo;

endmodule

`default_nettype wire

// File: rtl/core/adaptive_pedestal_tracker.sv
// Top level of the adaptive pedestal tracker: state memory, sequencer and report register.
// Sample and load beats read the channel entry when accepted and write it back from S_MOD;
// a sample that reaches the limit trigger first waits in S_LIM for the shared divider.
// A report beat walks the channels one at a time (read, divider launch, divider steps,
// hand-off to the report register), one divide per channel through the single divider.
// Reset is synchronous and active low; it clears the entry valid bits at once, so every entry
// reads as its reset value until first written, and no clearing pass is needed.
`default_nettype none

module adaptive_pedestal_tracker #(
    parameter int NUM_CHAN   = 16,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    apt_in_if.sink                              i_cmd,
    apt_out_if.source                           o_rpt,
    input  wire logic                           i_cfg_we,
    input  wire logic [apt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [apt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import apt_pkg::*;

    // Address width of the state memory; channel numbers are widened to EXT_W before slicing.
    localparam int AW    = (NUM_CHAN > 1) ? $clog2(NUM_CHAN) : 1;
    localparam int EXT_W = 8;
    // Width in which counts are compared against output limits and thresholds.
    localparam int XW    = (COUNT_BITS > OCNT_W) ? COUNT_BITS : OCNT_W;
    // Channels a report can cover.
    localparam int RPT_LIM = (NUM_CHAN < MAX_RPT) ? NUM_CHAN : MAX_RPT;

    // One memory word holds the per-channel sum, count, limit and mean.
    typedef struct packed {
        logic [SUM_W-1:0]      sum;
        logic [COUNT_BITS-1:0] cnt;
        logic [LIMIT_W-1:0]    limit;
        logic [PED_W-1:0]      mean;
    } t_entry;

    localparam t_entry ENT_RST = '{sum: '0, cnt: '0, limit: LIMIT_MAX, mean: '0};

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [MINP_W-1:0]   r_min_peds;
    logic [TRIG_W-1:0]   r_trig;
    logic [NCH_W-1:0]    r_num_ch;
    logic [NCH_W-1:0]    r_nrep, n_nrep;
    logic [CH_W-1:0]     r_idx, n_idx;
    logic [AW-1:0]       r_addr, n_addr;
    logic                r_ch_ok, n_ch_ok;
    t_cmd                r_cmd, n_cmd;
    logic [VAL_W-1:0]    r_val, n_val;
    t_entry              r_ent, n_ent;
    logic [NUM_CHAN-1:0] r_vld;
    logic                r_ovld, n_ovld;
    t_rpt                r_rpt, n_rpt;

    // State memory and its registered read port.
    t_entry              mem [NUM_CHAN];
    t_entry              r_rd;
    logic                r_rd_vld;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                in_acc;
    logic [EXT_W-1:0]    ch_ext;
    logic [EXT_W-1:0]    idx_ext;
    logic [AW-1:0]       ch_addr;
    logic [AW-1:0]       idx_addr;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                mem_we;
    t_entry              mem_wdata;
    t_entry              ent_cur;
    logic                slot_free;
    logic                out_load;

    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_new;
    logic [COUNT_BITS-1:0] cnt_new;
    logic                smp_take;
    logic                trig_hit;
    logic [LIMIT_W:0]    lim_sum;
    logic [LIMIT_W-1:0]  lim_new;
    logic [PED_W-1:0]    ped;
    logic                upd;
    logic [XW-1:0]       cnt_x;
    logic                last_rpt;

    logic [CFG_DATA_W+16:0] div5_prod;

    t_div_req            div_req;
    logic [COUNT_BITS-1:0] div_dvs;
    t_div_rsp            div_rsp;

    assign in_acc      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    assign ch_ext   = EXT_W'(i_cmd.channel);
    assign idx_ext  = EXT_W'(r_idx);
    assign ch_addr  = ch_ext[AW-1:0];
    assign idx_addr = idx_ext[AW-1:0];

    // While idle the read port follows the command channel so the entry is ready on the
    // cycle after the accept; otherwise it follows the report walk.
    assign rd_addr  = (r_state == S_IDLE) ? ch_addr : idx_addr;

    // An entry never written reads as its reset value.
    assign ent_cur   = r_rd_vld ? r_rd : ENT_RST;
    assign slot_free = !r_ovld || o_rpt.ready;

    // min_peds / 5 through a reciprocal multiply; exact over all 16-bit values.
    assign div5_prod = i_cfg_data * DIV5_RECIP;

    // Sample update arithmetic, all on the freshly read entry.
    always_comb begin
        sum_add  = {1'b0, ent_cur.sum} + (SUM_W + 1)'(r_val);
        sum_new  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        cnt_new  = ent_cur.cnt + 1'b1;
        smp_take = r_ch_ok && (r_val <= ent_cur.limit) && (ent_cur.cnt != {COUNT_BITS{1'b1}});
        trig_hit = (XW'(cnt_new) == XW'(r_trig));
    end

    // Divider results: new limit after a trigger, pedestal during a report walk.
    always_comb begin
        lim_sum = {1'b0, div_rsp.quot[LIMIT_W-1:0]} + LIMIT_OFS;
        if ((|div_rsp.quot[DIVD_W-1:LIMIT_W]) || lim_sum[LIMIT_W]) begin
            lim_new = LIMIT_MAX;
        end else begin
            lim_new = lim_sum[LIMIT_W-1:0];
        end
        ped      = (|div_rsp.quot[DIVD_W-1:PED_W]) ? PED_MAX : div_rsp.quot[PED_W-1:0];
        cnt_x    = XW'(r_ent.cnt);
        upd      = (r_min_peds != '0) && (cnt_x > XW'(r_min_peds));
        last_rpt = ((NCH_W'(r_idx) + 1'b1) == r_nrep);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_nrep    = r_nrep;
        n_idx     = r_idx;
        n_addr    = r_addr;
        n_ch_ok   = r_ch_ok;
        n_cmd     = r_cmd;
        n_val     = r_val;
        n_ent     = r_ent;
        n_ovld    = r_ovld;
        n_rpt     = r_rpt;
        mem_we    = 1'b0;
        mem_wdata = r_ent;
        wr_addr   = r_addr;
        out_load  = 1'b0;
        div_req   = '{start: 1'b0, dividend: {r_ent.sum, {FRAC_W{1'b0}}}};
        div_dvs   = (r_ent.cnt == '0) ? COUNT_BITS'(1) : r_ent.cnt;

        if (r_ovld && o_rpt.ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = t_cmd'(i_cmd.command);
                    n_val   = i_cmd.value;
                    n_addr  = ch_addr;
                    n_ch_ok = (ch_ext < EXT_W'(NUM_CHAN));
                    n_idx   = '0;
                    if (i_cmd.command == CMD_SAMPLE || i_cmd.command == CMD_LOAD) begin
                        n_state = S_MOD;
                    end else if (i_cmd.command == CMD_REPORT) begin
                        n_nrep = (r_num_ch < NCH_W'(RPT_LIM)) ? r_num_ch : NCH_W'(RPT_LIM);
                        if (n_nrep != '0) begin
                            n_state = S_WRD;
                        end
                    end
                end
            end

            S_MOD: begin
                // Read-modify-write of one entry. The next read of any entry starts only
                // after this write, so no forwarding path is needed.
                n_state = S_IDLE;
                if (r_cmd == CMD_LOAD) begin
                    mem_wdata       = ent_cur;
                    mem_wdata.limit = r_val;
                    mem_we          = r_ch_ok;
                end else if (smp_take) begin
                    n_ent     = '{sum: sum_new, cnt: cnt_new, limit: ent_cur.limit,
                                  mean: ent_cur.mean};
                    mem_wdata = n_ent;
                    if (trig_hit) begin
                        // Hold the write until the mean for the new limit is known.
                        div_req = '{start: 1'b1, dividend: DIVD_W'(sum_new)};
                        div_dvs = cnt_new;
                        n_state = S_LIM;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
            end

            S_LIM: begin
                if (!div_rsp.busy) begin
                    mem_wdata       = r_ent;
                    mem_wdata.limit = lim_new;
                    mem_we          = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            S_WRD: begin
                n_state = S_WDIV;
            end

            S_WDIV: begin
                n_ent   = ent_cur;
                div_req = '{start: 1'b1, dividend: {ent_cur.sum, {FRAC_W{1'b0}}}};
                div_dvs = (ent_cur.cnt == '0) ? COUNT_BITS'(1) : ent_cur.cnt;
                n_state = S_WWAIT;
            end

            S_WWAIT: begin
                if (!div_rsp.busy && slot_free) begin
                    out_load           = 1'b1;
                    n_ovld             = 1'b1;
                    n_rpt.out_channel  = r_idx;
                    n_rpt.pedestal_q4  = ped;
                    n_rpt.threshold_q4 = THR_W'(ped) + THR_OFS;
                    n_rpt.held_mean_q4 = upd ? ped : r_ent.mean;
                    n_rpt.sample_count = (cnt_x > XW'(OCNT_MAX)) ? OCNT_MAX : cnt_x[OCNT_W-1:0];
                    n_rpt.mean_updated = upd;
                    n_rpt.last         = last_rpt;
                    mem_wdata          = r_ent;
                    mem_wdata.mean     = ped;
                    mem_we             = upd;
                    wr_addr            = idx_addr;
                    if (last_rpt) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_WRD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovld     <= 1'b0;
            r_vld      <= '0;
            r_min_peds <= MINP_RST;
            r_trig     <= TRIG_RST;
            r_num_ch   <= NCH_RST;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            if (mem_we) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MIN_PEDS: begin
                        r_min_peds <= i_cfg_data[MINP_W-1:0];
                        r_trig     <= div5_prod[DIV5_SHIFT +: TRIG_W];
                    end
                    CFG_NUM_CHAN: begin
                        r_num_ch <= i_cfg_data[NCH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working registers of the sequencer; payload only, no reset.
    always_ff @(posedge i_clk) begin
        r_nrep  <= n_nrep;
        r_idx   <= n_idx;
        r_addr  <= n_addr;
        r_ch_ok <= n_ch_ok;
        r_cmd   <= n_cmd;
        r_val   <= n_val;
        r_ent   <= n_ent;
        r_rpt   <= n_rpt;
    end

    // State memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= mem_wdata;
        end
        r_rd     <= mem[rd_addr];
        r_rd_vld <= r_vld[rd_addr];
    end

    // ------------------------------------------------------------------
    // Shared divider
    // ------------------------------------------------------------------
    apt_div #(
        .CNT_W (COUNT_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_divisor (div_dvs),
        .o_rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // Report register drives the output beat.
    // ------------------------------------------------------------------
    assign o_rpt.valid        = r_ovld;
    assign o_rpt.out_channel  = r_rpt.out_channel;
    assign o_rpt.pedestal_q4  = r_rpt.pedestal_q4;
    assign o_rpt.threshold_q4 = r_rpt.threshold_q4;
    assign o_rpt.held_mean_q4 = r_rpt.held_mean_q4;
    assign o_rpt.sample_count = r_rpt.sample_count;
    assign o_rpt.mean_updated = r_rpt.mean_updated;
    assign o_rpt.last         = r_rpt.last;

`ifndef SYNTHESIS
    // The divider is never relaunched while a division is still running.
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A report never overwrites one that is still waiting to be taken.
    a_rpt_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_ovld || o_rpt.ready))
        else $error("report register overwritten");

    // The walk stays within the channels that the report covers.
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRD) |-> (NCH_W'(r_idx) < r_nrep))
        else $error("report walk beyond channel count");

    // No memory write coincides with an accepted command beat.
    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !mem_we)
        else $error("memory write while accepting a beat");
`endif

endmodule

`default_nettype wire
